// ----- hw/rtl/http_chunked_body_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder assertion macros
// shared property forms for the chunked decoder checkers
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, off in reset
`define HCBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off in reset
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// types, codes and helpers of the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int unsigned SIZE_BITS_DEF = 32;
    localparam int unsigned DROP_BYTES    = 2;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_BODY    = 3'd1,
        PH_DROP    = 3'd2,
        PH_TRAILER = 3'd3,
        PH_ERROR   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        SCAN_LEAD   = 2'd0,
        SCAN_DIGITS = 2'd1,
        SCAN_REST   = 2'd2
    } t_scan;

    typedef enum logic [1:0] {
        KIND_BODY     = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ERROR    = 2'd2
    } t_kind;

    // bit 4 set when the byte is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// byte-wide decoder for http/1.1 chunked transfer coding
// ----------------------------------------------------------------------------
// Takes the raw chunked stream one byte per input beat and gives one output
// beat per decoded body byte, one per finished message (kind complete) and
// one per byte from a format error on (kind error, sticky until reset).
// Size lines, chunk trailers and the crlf after each chunk make no output.
// Every input byte is handled at the accepting edge: the parser state and
// the size counter update there and any result lands in the output
// register, so the block takes one byte per clock as long as the output
// side keeps taking beats. s_axis_tready is high whenever the
// output register is empty or being drained in the same
// cycle. The size counter is SIZE_BITS wide; a size needing more bits is an
// error. Leading space, tab, vt and ff are skipped on a size line, cr is
// ignored in size and trailer lines, and the size ends at the first non-hex
// byte (a 0x prefix stops at the x and reads as size zero, a sign leaves no
// digit at all).
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] body_byte
    output logic [1:0] m_axis_tuser    // [1:0] kind
);
    import hcbd_pkg::*;

    // parser state
    t_phase               r_phase, n_phase;
    t_scan                r_scan, n_scan;
    logic [SIZE_BITS-1:0] r_count, n_count;
    logic                 r_digit_seen, n_digit_seen;
    logic                 r_line_nonempty, n_line_nonempty;

    // output register
    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic [7:0]           r_out_byte;

    logic                 in_beat;
    logic [4:0]           hex;
    logic                 is_hex;
    logic                 is_space;
    logic                 oversize;
    logic [SIZE_BITS-1:0] drop_next;

    // result of the current byte
    logic                 emit;
    t_kind                emit_kind;
    logic [7:0]           emit_byte;

    // output register frees up when empty or when its beat goes out now
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign hex      = hex_decode(s_axis_tdata);
    assign is_hex   = hex[4];
    assign is_space = (s_axis_tdata inside {CH_SPACE, CH_TAB, CH_VT, CH_FF});
    // another digit would push a set bit out of the top nibble
    assign oversize = (r_count[SIZE_BITS-1 -: 4] != 4'd0);
    assign drop_next = (r_count != '0) ? r_count - SIZE_BITS'(1) : '0;

    // next state
    always_comb begin
        n_phase         = r_phase;
        n_scan          = r_scan;
        n_count         = r_count;
        n_digit_seen    = r_digit_seen;
        n_line_nonempty = r_line_nonempty;
        if (in_beat) begin
            case (r_phase)
                PH_SIZE: begin
                    if (s_axis_tdata == CH_CR) begin
                        // ignored anywhere in the line
                    end else if (s_axis_tdata == CH_LF) begin
                        if (!r_digit_seen) begin
                            n_phase = PH_ERROR;
                        end else if (r_count == '0) begin
                            n_phase         = PH_TRAILER;
                            n_line_nonempty = 1'b0;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end else if (r_scan == SCAN_REST) begin
                        // chunk extension or junk after the size
                    end else if (!is_hex) begin
                        if (!(r_scan == SCAN_LEAD && is_space)) begin
                            n_scan = SCAN_REST;
                        end
                    end else begin
                        n_scan       = SCAN_DIGITS;
                        n_digit_seen = 1'b1;
                        if (oversize) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_count = {r_count[SIZE_BITS-5:0], hex[3:0]};
                        end
                    end
                end
                PH_BODY: begin
                    n_count = r_count - SIZE_BITS'(1);
                    if (r_count == SIZE_BITS'(1)) begin
                        n_phase = PH_DROP;
                        n_count = SIZE_BITS'(DROP_BYTES);
                    end
                end
                PH_DROP: begin
                    n_count = drop_next;
                    if (drop_next == '0) begin
                        n_phase         = PH_SIZE;
                        n_scan          = SCAN_LEAD;
                        n_digit_seen    = 1'b0;
                        n_line_nonempty = 1'b0;
                    end
                end
                PH_TRAILER: begin
                    if (s_axis_tdata == CH_CR) begin
                        // ignored
                    end else if (s_axis_tdata == CH_LF) begin
                        if (!r_line_nonempty) begin
                            // empty line closes the message, rearm
                            n_phase         = PH_SIZE;
                            n_count         = '0;
                            n_scan          = SCAN_LEAD;
                            n_digit_seen    = 1'b0;
                            n_line_nonempty = 1'b0;
                        end else begin
                            n_line_nonempty = 1'b0;
                        end
                    end else begin
                        n_line_nonempty = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    // result of the current byte
    always_comb begin
        emit      = 1'b0;
        emit_kind = KIND_BODY;
        emit_byte = 8'd0;
        case (r_phase)
            PH_SIZE: begin
                if (s_axis_tdata == CH_LF) begin
                    if (!r_digit_seen) begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERROR;
                    end
                end else if (s_axis_tdata != CH_CR && r_scan != SCAN_REST &&
                             is_hex && oversize) begin
                    emit      = 1'b1;
                    emit_kind = KIND_ERROR;
                end
            end
            PH_BODY: begin
                emit      = 1'b1;
                emit_kind = KIND_BODY;
                emit_byte = s_axis_tdata;
            end
            PH_DROP: begin
                emit = 1'b0;
            end
            PH_TRAILER: begin
                if (s_axis_tdata == CH_LF && !r_line_nonempty) begin
                    emit      = 1'b1;
                    emit_kind = KIND_COMPLETE;
                end
            end
            default: begin
                emit      = 1'b1;
                emit_kind = KIND_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SIZE;
            r_scan          <= SCAN_LEAD;
            r_count         <= '0;
            r_digit_seen    <= 1'b0;
            r_line_nonempty <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_scan          <= n_scan;
            r_count         <= n_count;
            r_digit_seen    <= n_digit_seen;
            r_line_nonempty <= n_line_nonempty;
        end
    end

    // output register: load on a byte with a result, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && emit) begin
            r_out_kind <= emit_kind;
            r_out_byte <= emit_byte;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_kind;

endmodule

// ----- hw/rtl/hcbd_checker.sv -----
// ----------------------------------------------------------------------------
// hcbd_checker
// port-level checks of the chunked body decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_assert.svh"

module hcbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);
    import hcbd_pkg::*;

    logic r_err_seen;
    logic out_beat;

    assign out_beat = m_axis_tvalid && m_axis_tready;

    // an error beat has gone out since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (out_beat && m_axis_tuser == KIND_ERROR) begin
            r_err_seen <= 1'b1;
        end
    end

    `HCBD_ASSERT_NOW(a_kind_legal, m_axis_tvalid, m_axis_tuser == KIND_BODY || m_axis_tuser == KIND_COMPLETE || m_axis_tuser == KIND_ERROR, "illegal output kind")
    `HCBD_ASSERT_NOW(a_byte_zero, m_axis_tvalid && m_axis_tuser != KIND_BODY, m_axis_tdata == 8'd0, "nonzero byte on a status beat")
    `HCBD_ASSERT_NOW(a_err_sticky, m_axis_tvalid && r_err_seen, m_axis_tuser == KIND_ERROR, "output after an error is not an error")
    `HCBD_ASSERT_NOW(a_ready_empty, !m_axis_tvalid, s_axis_tready, "input stalled with an empty output")
    `HCBD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output beat changed")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- sim/http_chunked_body_decoder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_test
// self-checking bench for the chunked transfer decoder
// ----------------------------------------------------------------------------
// Feeds raw chunked byte streams into the decoder and predicts every output
// beat with a local copy of the decoder state. A short directed stream goes
// first. Random well-formed messages with noisy size lines, extensions,
// trailers and random drop bytes follow under four idling mixes. Then the
// receiver holds off for a long stretch during a long chunk. A single
// malformed size line ends the run, because a format error is sticky until
// reset.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_test;

    import hcbd_pkg::*;

    localparam int unsigned SIZE_W       = SIZE_BITS_DEF;
    localparam int unsigned LIMIT_CYCLES = 250_000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_BYTES  = 110;

    // one decoded output beat
    typedef struct packed {
        t_kind      kind;
        logic [7:0] body;
    } t_out_beat;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] body_byte
    logic [1:0] m_axis_tuser;            // [1:0] kind

    // idling knobs, in percent of cycles
    int unsigned src_idle_pct   = 0;
    int unsigned snk_stall_pct  = 0;
    logic        hold_active    = 1'b0;
    event        hold_off_start;

    int unsigned bytes_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // beats the decoder still owes, oldest first
    t_out_beat due_beats [$];

    // local copy of the decoder state
    t_phase      dec_phase;
    logic [63:0] dec_count;
    t_scan       dec_scan;
    logic        dec_digit_seen;
    logic        dec_line_busy;

    http_chunked_body_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // hex value of a byte, -1 when it is not a hex digit
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void restart_size_line();
        dec_phase      = PH_SIZE;
        dec_count      = '0;
        dec_scan       = SCAN_LEAD;
        dec_digit_seen = 1'b0;
        dec_line_busy  = 1'b0;
    endfunction

    // advances the decoder copy by one input byte, returns 1 with the beat
    // that the byte causes, if any
    function automatic bit decode_byte(input logic [7:0] c, output t_out_beat beat);
        int h;
        beat.kind = KIND_BODY;
        beat.body = 8'h00;
        case (dec_phase)
            PH_SIZE: begin
                if (c == CH_CR) return 0;
                if (c == CH_LF) begin
                    if (!dec_digit_seen) begin
                        dec_phase = PH_ERROR;
                        beat.kind = KIND_ERROR;
                        return 1;
                    end
                    if (dec_count == 0) begin
                        dec_phase     = PH_TRAILER;
                        dec_line_busy = 1'b0;
                    end else begin
                        dec_phase = PH_BODY;
                    end
                    return 0;
                end
                if (dec_scan == SCAN_REST) return 0;
                h = hex_digit(c);
                if (h < 0) begin
                    // blanks are skipped only ahead of the first digit
                    if (!(dec_scan == SCAN_LEAD && (c == CH_SPACE || c == CH_TAB ||
                                                    c == CH_VT || c == CH_FF))) begin
                        dec_scan = SCAN_REST;
                    end
                    return 0;
                end
                dec_scan       = SCAN_DIGITS;
                dec_digit_seen = 1'b1;
                // next digit would not fit in the size counter
                if ((dec_count >> (SIZE_W - 4)) != 0) begin
                    dec_phase = PH_ERROR;
                    beat.kind = KIND_ERROR;
                    return 1;
                end
                dec_count = {dec_count[59:0], 4'(h)};
                return 0;
            end
            PH_BODY: begin
                dec_count = dec_count - 64'd1;
                if (dec_count == 0) begin
                    dec_phase = PH_DROP;
                    dec_count = 64'(DROP_BYTES);
                end
                beat.body = c;
                return 1;
            end
            PH_DROP: begin
                if (dec_count > 0) dec_count = dec_count - 64'd1;
                if (dec_count == 0) restart_size_line();
                return 0;
            end
            PH_TRAILER: begin
                if (c == CH_CR) return 0;
                if (c == CH_LF) begin
                    // an empty trailer line closes the message
                    if (!dec_line_busy) begin
                        restart_size_line();
                        beat.kind = KIND_COMPLETE;
                        return 1;
                    end
                    dec_line_busy = 1'b0;
                    return 0;
                end
                dec_line_busy = 1'b1;
                return 0;
            end
            default: begin
                dec_phase = PH_ERROR;
                beat.kind = KIND_ERROR;
                return 1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // checking: output beat against the oldest due beat, then input beat
    // into the prediction; values are the ones sampled by this edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat got;
        if (!i_rst_n) begin
            restart_size_line();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = t_kind'(m_axis_tuser);
                got.body = m_axis_tdata;
                if (due_beats.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: output beat with none due: kind %0d byte %02h",
                                 $realtime, got.kind, got.body);
                    end
                end else begin
                    want = due_beats.pop_front();
                    if (got.kind !== want.kind || got.body !== want.body) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: expected kind %0d byte %02h, got kind %0d byte %02h",
                                     $realtime, want.kind, want.body, got.kind, got.body);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (decode_byte(s_axis_tdata, want)) due_beats.insert(due_beats.size(), want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_active && ($urandom_range(99) >= snk_stall_pct);
    end

    // long receiver hold-off, counted here so the sender keeps offering
    initial begin
        forever begin
            @(hold_off_start);
            @(posedge i_clk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stream building
    // ------------------------------------------------------------------------

    // offers one byte and returns at the edge that takes it; tvalid stays
    // high after the beat so back-to-back bytes need no extra step
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] byte_but_lf();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_LF);
        return c;
    endfunction

    task automatic send_line_end();
        if ($urandom_range(3) != 0) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // size line with random blanks, leading zeros, letter case and tail
    task automatic send_size_line(input int unsigned size);
        logic [7:0] blanks [5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
        string      digits;
        logic [7:0] c;
        int         zeros;
        repeat ($urandom_range(2)) send_byte(blanks[$urandom_range(4)]);
        // now and then four to ten zeros, which with the digits can exceed the counter width in digits
        zeros  = ($urandom_range(7) == 0) ? $urandom_range(10, 4) : $urandom_range(1);
        digits = $sformatf("%0h", size);
        repeat (zeros) send_byte("0");
        for (int i = 0; i < digits.len(); i++) begin
            c = digits[i];
            if (c >= "a" && $urandom_range(1)) c = c - 8'h20;
            send_byte(c);
        end
        case ($urandom_range(3))
            1: begin
                // chunk extension
                send_byte(";");
                repeat ($urandom_range(5)) send_byte(byte_but_lf());
            end
            2: begin
                // any non-hex byte ends the digits, the rest is ignored
                do c = 8'($urandom_range(255));
                while (hex_digit(c) >= 0 || c == CH_CR || c == CH_LF);
                send_byte(c);
                repeat ($urandom_range(4)) send_byte(byte_but_lf());
            end
            default: ;
        endcase
        send_line_end();
    endtask

    task automatic send_chunk(input int unsigned len);
        send_size_line(len);
        repeat (len) send_byte(8'($urandom_range(255)));
        // the two bytes after the body are dropped whatever they hold
        if ($urandom_range(4) == 0) begin
            repeat (2) send_byte(8'($urandom_range(255)));
        end else begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
    endtask

    // one well-formed message: chunks, last chunk, trailers, empty line
    task automatic send_message();
        repeat ($urandom_range(3, 1)) begin
            send_chunk(($urandom_range(9) == 0) ? $urandom_range(64, 17)
                                                : $urandom_range(12, 1));
        end
        if ($urandom_range(5) == 0) begin
            // a 0x prefix leaves a size of zero
            send_byte("0");
            send_byte("x");
            send_byte("1");
            send_byte("f");
            send_line_end();
        end else begin
            send_size_line(0);
        end
        repeat ($urandom_range(2)) begin
            send_byte(8'($urandom_range(255, 14)));
            repeat ($urandom_range(6)) send_byte(byte_but_lf());
            send_line_end();
        end
        send_line_end();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // blanks before the size, extension, body extremes, drop bytes that
    // hold a line feed and a digit, one trailer line, completion
    task automatic test_directed();
        logic [7:0] stream [20] = '{
            CH_SPACE, CH_TAB, CH_VT, CH_FF, "2", ";", "x", CH_CR, CH_LF,
            8'h00, 8'hff,
            CH_LF, "5",
            "0", CH_LF,
            "t", CH_CR, CH_LF,
            CH_CR, CH_LF
        };
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        foreach (stream[i]) send_byte(stream[i]);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int unsigned start_count;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        start_count   = bytes_sent;
        while (bytes_sent - start_count < PHASE_BYTES) send_message();
    endtask

    // receiver holds off during a long chunk so the input side stalls
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        -> hold_off_start;
        send_chunk(48);
        send_byte("0");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // one malformed size line, then every byte reports the error
    task automatic test_sticky_error();
        string nonzero = "123456789abcdef";
        src_idle_pct  = 26;
        snk_stall_pct = 26;
        case ($urandom_range(3))
            0: begin
                // no digit on the line
                send_byte(CH_SPACE);
                send_byte(";");
                send_byte(CH_LF);
            end
            1: begin
                send_byte("+");
                send_byte("4");
                send_byte(CH_LF);
            end
            2: begin
                send_byte("-");
                send_byte("4");
                send_byte(CH_LF);
            end
            default: begin
                // nine significant digits overflow the size counter
                send_byte(nonzero[$urandom_range(14)]);
                repeat (8) send_byte(nonzero[$urandom_range(14)]);
            end
        endcase
        send_byte(8'h00);
        send_byte(8'hff);
        repeat (8) send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(0, 0);
        test_random_traffic(74, 0);
        test_random_traffic(0, 74);
        test_random_traffic(26, 26);
        test_backpressure();
        test_sticky_error();

        s_axis_tvalid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        mismatch_count += due_beats.size();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- http_chunked_body_decoder.f -----
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/http_chunked_body_decoder.sv
hw/rtl/hcbd_checker.sv
sim/http_chunked_body_decoder_test.sv
